// ===== hdl/sspq_pkg.sv =====
// shared types and codes for the sorted priority queue
`timescale 1ns / 1ps
package sspq_pkg;

  localparam int DataW  = 8;
  localparam int PrioW  = 8;
  localparam int CountW = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } entry_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic             insert_en;
    logic             remove_en;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } cell_cmd_t;

endpackage

// ===== hdl/sspq_req_if.sv =====
// request channel: insert or remove
`timescale 1ns / 1ps
interface sspq_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] item_data;
  logic [7:0] item_priority;

  modport source (output valid, req_type, item_data, item_priority, input ready);
  modport sink   (input valid, req_type, item_data, item_priority, output ready);
endinterface

// ===== hdl/sspq_rsp_if.sv =====
// response channel: status, removed entry and fill level
`timescale 1ns / 1ps
interface sspq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] removed_data;
  logic [7:0] removed_priority;
  logic [4:0] entry_count;
  logic       is_empty;

  modport source (output valid, status, removed_data, removed_priority, entry_count,
                  is_empty, input ready);
  modport sink   (input valid, status, removed_data, removed_priority, entry_count,
                  is_empty, output ready);
endinterface

// ===== hdl/sspq_cell.sv =====
// one slot of the sorted row: holds an entry, shifts left or right
`timescale 1ns / 1ps
module sspq_cell
  import sspq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_keep,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      keep,
  output entry_t    entry
);

  entry_t entry_next;

  // an occupied slot whose priority is not above the new one stays put
  assign keep = occupied && (entry.prio <= cmd.prio);

  always_comb begin
    entry_next = entry;
    priority if (cmd.remove_en) begin
      entry_next = right_entry;
    end else if (cmd.insert_en && !keep) begin
      if (left_keep) begin
        entry_next.data = cmd.data;
        entry_next.prio = cmd.prio;
      end else begin
        entry_next = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/stable_sorted_priority_queue_core.sv =====
// Stable sorted priority queue: top level with the cell row and response register
//
// Requests arrive on req: req_type 0 inserts (item_data, item_priority), 1 removes
// the head. Each request transfer yields exactly one transfer on rsp carrying status
// (ok, underflow, overflow), the removed entry (zero unless a remove succeeded),
// the count after the request and an empty flag.
// Entries live in a row of CAPACITY cells kept in ascending priority order; equal
// priorities keep arrival order. On insert every cell compares its priority with the
// new one in parallel and either holds, takes the new entry, or takes its left
// neighbor's; on remove every cell takes its right neighbor's.
// rsp.valid is registered, rising in the cycle after a request transfer; one request
// is taken per cycle unless rsp stalls, limited by the single compare in each cell.
// A response register sits between the row and rsp: req.ready is high while that
// register is empty or is being drained, so a stall on rsp holds req off until the
// pending response is taken.
// Reset empties the queue (count to zero) and drops any pending response; slot
// contents are left as they are and are only read below the count.
`timescale 1ns / 1ps
module stable_sorted_priority_queue_core
  import sspq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic         clk,
  input logic         rst,
  sspq_req_if.sink    req,
  sspq_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] Full = CW'(CAPACITY);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            req_xfer;
  logic            is_full;
  logic            is_zero;
  cell_cmd_t       cmd;
  entry_t          cell_entry [CAPACITY];
  entry_t          right_entry [CAPACITY];
  logic [CAPACITY:0] keep;

  status_t         status_next;
  entry_t          removed_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign req_xfer  = req.valid && req.ready;
  assign is_full   = (count == Full);
  assign is_zero   = (count == '0);

  always_comb begin
    cmd.insert_en = req_xfer && (req.req_type == REQ_INSERT) && !is_full;
    cmd.remove_en = req_xfer && (req.req_type == REQ_REMOVE) && !is_zero;
    cmd.data      = req.item_data;
    cmd.prio      = req.item_priority;
  end

  // left boundary acts as a kept slot so the head takes the new entry
  assign keep[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry[i] = '0;
    end else begin : g_mid
      assign right_entry[i] = cell_entry[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CW'(i) < count),
      .left_keep   (keep[i]),
      .left_entry  ((i == 0) ? entry_t'('0) : cell_entry[(i == 0) ? 0 : i-1]),
      .right_entry (right_entry[i]),
      .keep        (keep[i+1]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_next   = count;
    status_next  = ST_OK;
    removed_next = '0;
    unique case (req.req_type)
      REQ_INSERT: begin
        if (is_full) begin
          status_next = ST_OVERFLOW;
        end else begin
          count_next = count + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (is_zero) begin
          status_next = ST_UNDERFLOW;
        end else begin
          count_next   = count - CW'(1);
          removed_next = cell_entry[0];
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (req_xfer) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      rsp.status           <= status_next;
      rsp.removed_data     <= removed_next.data;
      rsp.removed_priority <= removed_next.prio;
      rsp.entry_count      <= 5'(count_next);
      rsp.is_empty         <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    req_xfer && (req.req_type == REQ_INSERT) && !is_full |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_remove_head: assert property (@(posedge clk) disable iff (rst)
    cmd.remove_en |=> rsp.valid && (rsp.status == ST_OK)
                      && (rsp.removed_priority == $past(cell_entry[0].prio)))
    else $error("remove did not return the head");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.is_empty == (count == '0))
    else $error("empty flag disagrees with count");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("head entries out of order");

endmodule

// ===== test/stable_sorted_priority_queue_core_tb.sv =====
// testbench for the stable sorted priority queue core: directed and random request traffic
`timescale 1ns / 1ps
module stable_sorted_priority_queue_core_tb;
  import sspq_pkg::*;

  localparam int Capacity  = 16;
  localparam int StallLimit = 4000;

  typedef struct {
    status_t    status;
    logic [7:0] removed_data;
    logic [7:0] removed_priority;
    logic [4:0] entry_count;
    logic       is_empty;
  } queue_response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sspq_req_if req_ch ();
  sspq_rsp_if rsp_ch ();

  stable_sorted_priority_queue_core #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the sorted store
  logic [7:0] shadow_data [Capacity];
  logic [7:0] shadow_prio [Capacity];
  int         shadow_count;

  queue_response_t awaited_responses [$];
  int              mismatch_count;
  int              sender_idle_pct;
  int              receiver_stall_pct;
  int              quiet_cycles;

  function automatic queue_response_t shadow_queue_apply(req_type_t kind, logic [7:0] data,
                                                         logic [7:0] prio);
    queue_response_t r;
    int slot;
    int i;
    r.status           = ST_OK;
    r.removed_data     = 8'd0;
    r.removed_priority = 8'd0;
    if (kind == REQ_INSERT) begin
      if (shadow_count >= Capacity) begin
        r.status = ST_OVERFLOW;
      end else begin
        // goes behind every entry of equal or lower priority value
        slot = 0;
        while (slot < shadow_count && shadow_prio[slot] <= prio) slot++;
        for (i = shadow_count; i > slot; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[slot] = data;
        shadow_prio[slot] = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.removed_data     = shadow_data[0];
        r.removed_priority = shadow_prio[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_data[i-1] = shadow_data[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    r.entry_count = 5'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  task automatic send_request(input req_type_t kind, input logic [7:0] data,
                              input logic [7:0] prio);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= 1'($urandom_range(1));
      req_ch.item_data     <= 8'($urandom_range(255));
      req_ch.item_priority <= 8'($urandom_range(255));
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.item_data     <= data;
    req_ch.item_priority <= prio;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_responses.push_back(shadow_queue_apply(kind, data, prio));
  endtask

  // hold the request side off until every response has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    queue_response_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_responses.size() == 0) begin
        mismatch_count++;
        $display("%0t: response transfer with none expected, expected none actual status %0d",
                 $time, rsp_ch.status);
      end else begin
        want = awaited_responses.pop_front();
        check_field("status", 8'(want.status), 8'(rsp_ch.status));
        check_field("removed_data", want.removed_data, rsp_ch.removed_data);
        check_field("removed_priority", want.removed_priority, rsp_ch.removed_priority);
        check_field("entry_count", 8'(want.entry_count), 8'(rsp_ch.entry_count));
        check_field("is_empty", 8'(want.is_empty), 8'(rsp_ch.is_empty));
      end
    end
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("stable_sorted_priority_queue_core verification failed");
      $finish;
    end
  end

  task automatic test_underflow_on_empty();
    send_request(REQ_REMOVE, 8'hFF, 8'hFF);
    send_request(REQ_REMOVE, 8'h00, 8'h00);
  endtask

  // extremes of both fields plus a run of equal priorities to check arrival order
  task automatic test_fill_with_ties();
    logic [7:0] fill_data [16];
    logic [7:0] fill_prio [16];
    fill_data = '{8'h00, 8'hFF, 8'h11, 8'h22, 8'h33, 8'hAA, 8'h55, 8'h44,
                  8'h66, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h80, 8'h7F};
    fill_prio = '{8'hFF, 8'h00, 8'h07, 8'h07, 8'h07, 8'h55, 8'hAA, 8'h00,
                  8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h07, 8'h40, 8'h00};
    for (int k = 0; k < 16; k++) begin
      send_request(REQ_INSERT, fill_data[k], fill_prio[k]);
    end
  endtask

  task automatic test_overflow_then_head_removal();
    send_request(REQ_INSERT, 8'hA5, 8'h00);
    for (int k = 0; k < 5; k++) begin
      send_request(REQ_REMOVE, 8'h5A, 8'hC3);
    end
  endtask

  task automatic test_random_traffic(input int item_total);
    int insert_pct;
    int run_left;
    logic [7:0] prio;
    insert_pct = 50;
    run_left   = 0;
    for (int k = 0; k < item_total; k++) begin
      // alternate filling, draining and balanced runs so both bounds get hit
      if (run_left == 0) begin
        run_left = $urandom_range(40, 10);
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      run_left--;
      if ($urandom_range(1) == 0) prio = 8'($urandom_range(3));
      else prio = 8'($urandom_range(255));
      if ($urandom_range(99) < insert_pct) begin
        send_request(REQ_INSERT, 8'($urandom_range(255)), prio);
      end else begin
        send_request(REQ_REMOVE, 8'($urandom_range(255)), prio);
      end
      if (k == item_total / 2) wait_drained();
    end
  endtask

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = 1'b0;
    req_ch.item_data     = 8'd0;
    req_ch.item_priority = 8'd0;
    rsp_ch.ready         = 1'b0;
    shadow_count         = 0;
    mismatch_count       = 0;
    quiet_cycles         = 0;
    sender_idle_pct      = 28;
    receiver_stall_pct   = 57;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_underflow_on_empty();
    test_fill_with_ties();
    test_overflow_then_head_removal();
    test_random_traffic(445);

    sender_idle_pct    = 57;
    receiver_stall_pct = 28;
    test_random_traffic(445);

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_traffic(445);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_responses.size() == 0) begin
      $display("stable_sorted_priority_queue_core verification clean");
    end else begin
      $display("stable_sorted_priority_queue_core verification failed");
    end
    $finish;
  end

endmodule
